@@ hw/rtl/ddct_pkg.sv @@
// Shared types and constants for the dual down-counting timer.
// Register offsets, control bit positions, bus op codes and the reload helper.
// No dependencies.
`default_nettype none

package ddct_pkg;

	typedef logic [1:0]  op_t;
	typedef logic [4:0]  reg_off_t;
	typedef logic [7:0]  ctrl_t;
	typedef logic [31:0] word_t;

	localparam op_t OP_READ  = 2'd0;
	localparam op_t OP_WRITE = 2'd1;
	localparam op_t OP_TICK  = 2'd2;

	// offsets within one timer's 32-byte window
	localparam reg_off_t REG_LOAD   = 5'h00;
	localparam reg_off_t REG_VALUE  = 5'h04;
	localparam reg_off_t REG_CTRL   = 5'h08;
	localparam reg_off_t REG_INTCLR = 5'h0C;
	localparam reg_off_t REG_RIS    = 5'h10;
	localparam reg_off_t REG_MIS    = 5'h14;
	localparam reg_off_t REG_BGLOAD = 5'h18;

	localparam int CTL_ONE_SHOT = 0;
	localparam int CTL_SIZE     = 1;
	localparam int CTL_INT_EN   = 5;
	localparam int CTL_MODE     = 6;
	localparam int CTL_ENABLE   = 7;

	localparam ctrl_t CTRL_RESET  = 8'h20;
	localparam word_t COUNT_RESET = 32'hFFFF_FFFF;
	localparam word_t DEC_RESET   = 32'd1000;
	localparam word_t FREE_16     = 32'h0000_FFFF;
	localparam word_t FREE_32     = 32'hFFFF_FFFF;

	// period loaded on expiry or on enable rising
	function automatic word_t reload_val(input ctrl_t ctrl, input word_t load);
		word_t v;
		if (ctrl[CTL_MODE]) begin
			v = load;
		end else if (ctrl[CTL_SIZE]) begin
			v = FREE_32;
		end else begin
			v = FREE_16;
		end
		return v;
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/dual_down_counter_timer_core.sv @@
// Dual down-counting timer core: two timers behind a register bus with a tick op.
// An accepted beat passes through the input register (s1) and then the result register.
// One beat per cycle while out_stall is low; both timers update in one pass of the s1 stage.
// Reset (arst_n low, asynchronous): LOAD 0, VALUE all ones, CONTROL 0x20,
// interrupts, running and halt flags cleared, step 1000, pipeline empty.
// Depends on ddct_pkg.
`default_nettype none

module dual_down_counter_timer_core
	import ddct_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [31:0] cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  op,
	input  wire logic [11:0] offset,
	input  wire logic [31:0] wdata,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      rdata,
	output logic             hit,
	output logic             irq
);

	word_t dec_q;

	// input stage
	logic        valid_s1;
	op_t         op_s1;
	logic [11:0] offset_s1;
	word_t       wdata_s1;

	// timer state
	word_t load_q  [2];
	word_t count_q [2];
	ctrl_t ctrl_q  [2];
	logic  raw_q   [2];
	logic  run_q   [2];
	logic  halt_q  [2];

	word_t load_n  [2];
	word_t count_n [2];
	ctrl_t ctrl_n  [2];
	logic  raw_n   [2];
	logic  run_n   [2];
	logic  halt_n  [2];

	// result register
	logic  out_valid_q;
	word_t rdata_q;
	logic  hit_q;
	logic  irq_q;

	logic     adv;
	logic     commit;
	logic     in_acc;
	logic     in_blk;
	logic     sel;
	reg_off_t loc;
	word_t    rd_c;
	logic     hit_c;
	logic     irq_c;
	logic     irq_now;

	assign adv     = !out_valid_q || !out_stall;
	assign commit  = valid_s1 && adv;
	assign in_stall = valid_s1 && !adv;
	assign in_acc  = in_valid && !in_stall;

	assign in_blk = (offset_s1[11:6] == 6'd0);
	assign sel    = offset_s1[5];
	assign loc    = offset_s1[4:0];

	always_comb begin
		for (int t = 0; t < 2; t++) begin
			load_n[t]  = load_q[t];
			count_n[t] = count_q[t];
			ctrl_n[t]  = ctrl_q[t];
			raw_n[t]   = raw_q[t];
			run_n[t]   = run_q[t];
			halt_n[t]  = halt_q[t];
		end
		rd_c  = '0;
		hit_c = 1'b0;

		case (op_s1)
			OP_TICK: begin
				hit_c = 1'b1;
				for (int t = 0; t < 2; t++) begin
					if (run_q[t] && !halt_q[t]) begin
						if (count_q[t] <= dec_q) begin
							raw_n[t]   = 1'b1;
							count_n[t] = reload_val(ctrl_q[t], load_q[t]);
							if (ctrl_q[t][CTL_ONE_SHOT]) begin
								halt_n[t] = 1'b1;
							end
						end else begin
							count_n[t] = count_q[t] - dec_q;
						end
					end
				end
			end
			OP_READ: begin
				if (in_blk) begin
					unique case (loc) inside
						REG_LOAD, REG_BGLOAD: begin
							rd_c  = load_q[sel];
							hit_c = 1'b1;
						end
						REG_VALUE: begin
							rd_c  = count_q[sel];
							hit_c = 1'b1;
						end
						REG_CTRL: begin
							rd_c  = {24'd0, ctrl_q[sel]};
							hit_c = 1'b1;
						end
						REG_RIS: begin
							rd_c  = {31'd0, raw_q[sel]};
							hit_c = 1'b1;
						end
						REG_MIS: begin
							rd_c  = {31'd0, raw_q[sel] & ctrl_q[sel][CTL_INT_EN]};
							hit_c = 1'b1;
						end
						default: ;
					endcase
				end
			end
			OP_WRITE: begin
				if (in_blk) begin
					unique case (loc)
						REG_LOAD: begin
							load_n[sel]  = wdata_s1;
							count_n[sel] = wdata_s1;
							halt_n[sel]  = 1'b0;
							hit_c        = 1'b1;
						end
						REG_CTRL: begin
							ctrl_n[sel] = wdata_s1[7:0];
							hit_c       = 1'b1;
							if (wdata_s1[CTL_ENABLE] && !run_q[sel]) begin
								count_n[sel] = reload_val(wdata_s1[7:0], load_q[sel]);
								run_n[sel]   = 1'b1;
								halt_n[sel]  = 1'b0;
							end else if (!wdata_s1[CTL_ENABLE] && run_q[sel]) begin
								run_n[sel] = 1'b0;
							end
						end
						REG_INTCLR: begin
							raw_n[sel] = 1'b0;
							hit_c      = 1'b1;
						end
						REG_BGLOAD: begin
							load_n[sel] = wdata_s1;
							hit_c       = 1'b1;
						end
						default: ;
					endcase
				end
			end
			default: ;
		endcase

		irq_c = (raw_n[0] & ctrl_n[0][CTL_INT_EN]) | (raw_n[1] & ctrl_n[1][CTL_INT_EN]);
	end

	assign irq_now = (raw_q[0] & ctrl_q[0][CTL_INT_EN]) | (raw_q[1] & ctrl_q[1][CTL_INT_EN]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dec_q <= DEC_RESET;
		end else if (cfg_we) begin
			dec_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv || !valid_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_s1     <= op;
			offset_s1 <= offset;
			wdata_s1  <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int t = 0; t < 2; t++) begin
				load_q[t]  <= '0;
				count_q[t] <= COUNT_RESET;
				ctrl_q[t]  <= CTRL_RESET;
				raw_q[t]   <= 1'b0;
				run_q[t]   <= 1'b0;
				halt_q[t]  <= 1'b0;
			end
		end else if (commit) begin
			for (int t = 0; t < 2; t++) begin
				load_q[t]  <= load_n[t];
				count_q[t] <= count_n[t];
				ctrl_q[t]  <= ctrl_n[t];
				raw_q[t]   <= raw_n[t];
				run_q[t]   <= run_n[t];
				halt_q[t]  <= halt_n[t];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			rdata_q <= rd_c;
			hit_q   <= hit_c;
			irq_q   <= irq_c;
		end
	end

	assign out_valid = out_valid_q;
	assign rdata     = rdata_q;
	assign hit       = hit_q;
	assign irq       = irq_q;

`ifndef ASSERT_OFF
	// state only moves when a result is loaded, so a held result sees current irq
	a_irq_tracks_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (irq_q == irq_now))
		else $error("irq in result register differs from timer state");

	// a miss never carries read data
	a_miss_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !hit_q) |-> (rdata_q == '0))
		else $error("miss beat with nonzero rdata");

	// input side only stalls behind an occupied s1 stage
	a_stall_needs_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q))
		else $error("input stalled with room in the pipeline");
`endif

endmodule

`default_nettype wire
